FILE: hw/rtl/jsfe_pkg.sv
// Package for the JSON string field extractor.
// Holds the parse phase type, character codes, the key text and the result type.
// No dependencies.
package jsfe_pkg;

    // Parse phases of the extractor
    typedef enum logic [3:0] {
        PH_SEARCH = 4'd0,
        PH_WS1    = 4'd1,
        PH_WS2    = 4'd2,
        PH_VALUE  = 4'd3,
        PH_ESC    = 4'd4,
        PH_HEX    = 4'd5,
        PH_DONE   = 4'd6
    } phase_t;

    // Result kinds and finish status codes
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Character codes
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_QMARK     = 8'h3F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;

    // Key text without its closing quote; the closing quote is the incoming byte
    localparam int KEY_WIN_LEN = 8;
    localparam logic [7:0] KEY_CHARS [KEY_WIN_LEN] = '{
        8'h22, 8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74
    };

    // Hex digits skipped after a \u escape
    localparam logic [2:0] HEX_DIGITS = 3'd4;

    // Reset value of the byte limit
    localparam logic [15:0] MAX_BYTES_RESET = 16'd8191;

    // Result queue geometry
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    // One result item
    typedef struct packed {
        logic       kind;
        logic       status;
        logic [7:0] value;
        logic       final_flag;
    } result_t;

endpackage

FILE: hw/rtl/json_string_field_extractor.sv
// Top level of the JSON string field extractor: key search, value unescaping
// and a small result queue feeding the output stream. Depends on jsfe_pkg.
//
// A result beat is written into the result queue and presented from its head.
// Throughput: one input beat per cycle while the result queue has room for two results;
// a beat that causes two results (a byte and the finish) pushes both into the 4-entry queue.
// Reset: asynchronous, active low; clears the parse state and the queue and sets the
// byte limit to 8191. Parse state also returns to its start after every tlast beat.
module json_string_field_extractor (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: max_content_bytes
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // last_byte
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] value_byte
    output logic [1:0]  m_axis_tuser,   // [0] result_kind, [1] finish_status
    output logic        m_axis_tlast    // final_of_item
);
    import jsfe_pkg::*;

    // Parse state
    phase_t      phase_reg, phase_next;
    logic [7:0]  win_reg [KEY_WIN_LEN];
    logic [7:0]  win_next [KEY_WIN_LEN];
    logic [2:0]  hex_reg, hex_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] max_reg;

    // Result queue
    result_t             rq_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] rd_ptr_reg, wr_ptr_reg;
    logic [RQ_CNT_W-1:0] fill_reg, fill_next;

    // Step decode
    logic        accept;
    logic        pop;
    logic [7:0]  in_byte;
    logic        in_last;
    logic        key_hit;
    logic        is_ws;
    logic        c_emit;
    logic [7:0]  c_byte;
    logic        c_fin;
    logic        c_status;
    phase_t      c_phase;
    logic [2:0]  c_hex;
    logic        c_shift;
    logic        e_en;
    logic [7:0]  e_byte;
    logic [15:0] count_inc;
    logic        limit_hit;
    logic        f_en;
    logic        f_status;
    result_t     res0, res1;
    logic        res0_en, res1_en;
    logic [1:0]  push_n;

    assign in_byte = s_axis_tdata;
    assign in_last = s_axis_tlast;
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign pop     = m_axis_tvalid && m_axis_tready;

    // Accept only with room for two results
    assign s_axis_tready = (fill_reg <= RQ_CNT_W'(RQ_DEPTH - 2));

    // Compare the window against the key text
    always_comb
    begin
        key_hit = (in_byte == CH_QUOTE);
        for (int i = 0; i < KEY_WIN_LEN; i++)
        begin
            if (win_reg[i] != KEY_CHARS[i])
            begin
                key_hit = 1'b0;
            end
        end
    end

    assign is_ws = (in_byte == CH_SPACE) || (in_byte == CH_TAB) ||
                   (in_byte == CH_LF) || (in_byte == CH_CR);

    // Next phase and per-phase actions for this beat
    always_comb
    begin
        c_emit   = 1'b0;
        c_byte   = in_byte;
        c_fin    = 1'b0;
        c_status = STATUS_OK;
        c_phase  = phase_reg;
        c_hex    = hex_reg;
        c_shift  = 1'b0;
        case (phase_reg)
            PH_SEARCH:
            begin
                if (in_byte == CH_NUL)
                begin
                    c_fin    = 1'b1;
                    c_status = STATUS_FAIL;
                end
                else
                begin
                    c_shift = 1'b1;
                    if (key_hit)
                    begin
                        c_phase = PH_WS1;
                    end
                end
            end
            PH_WS1:
            begin
                if (in_byte == CH_COLON)
                begin
                    c_phase = PH_WS2;
                end
                else if (!is_ws)
                begin
                    c_fin    = 1'b1;
                    c_status = STATUS_FAIL;
                end
            end
            PH_WS2:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    c_phase = PH_VALUE;
                    if (max_reg == '0)
                    begin
                        c_fin = 1'b1;
                    end
                end
                else if (!is_ws)
                begin
                    c_fin    = 1'b1;
                    c_status = STATUS_FAIL;
                end
            end
            PH_VALUE:
            begin
                if (in_byte == CH_NUL || in_byte == CH_QUOTE)
                begin
                    c_fin = 1'b1;
                end
                else if (in_byte == CH_BACKSLASH)
                begin
                    c_phase = PH_ESC;
                end
                else
                begin
                    c_emit = 1'b1;
                end
            end
            PH_ESC:
            begin
                c_phase = PH_VALUE;
                c_emit  = 1'b1;
                case (in_byte)
                    CH_NUL:
                    begin
                        c_byte = CH_BACKSLASH;
                        c_fin  = 1'b1;
                    end
                    CH_LOWER_U:
                    begin
                        c_emit  = 1'b0;
                        c_phase = PH_HEX;
                        c_hex   = HEX_DIGITS;
                    end
                    CH_LOWER_N: c_byte = CH_LF;
                    CH_LOWER_R: c_byte = CH_CR;
                    CH_LOWER_T: c_byte = CH_TAB;
                    default:    c_byte = in_byte;
                endcase
            end
            PH_HEX:
            begin
                if (in_byte == CH_NUL)
                begin
                    c_fin    = 1'b1;
                    c_status = STATUS_FAIL;
                end
                else
                begin
                    c_hex = hex_reg - 3'd1;
                    if (c_hex == 3'd0)
                    begin
                        c_phase = PH_VALUE;
                        c_emit  = 1'b1;
                        c_byte  = CH_QMARK;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Form the results: at most one byte, then at most one finish
    always_comb
    begin
        e_en      = c_emit || (in_last && !c_fin && c_phase == PH_ESC);
        e_byte    = c_emit ? c_byte : CH_BACKSLASH;
        count_inc = count_reg + 16'd1;
        limit_hit = e_en && (count_inc >= max_reg);

        f_en     = 1'b0;
        f_status = STATUS_OK;
        if (c_fin)
        begin
            f_en     = 1'b1;
            f_status = c_status;
        end
        else if (limit_hit)
        begin
            f_en = 1'b1;
        end
        else if (in_last)
        begin
            if (c_phase == PH_VALUE || c_phase == PH_ESC)
            begin
                f_en = 1'b1;
            end
            else if (c_phase != PH_DONE)
            begin
                f_en     = 1'b1;
                f_status = STATUS_FAIL;
            end
        end

        res0_en = e_en || f_en;
        res1_en = e_en && f_en;
        if (e_en)
        begin
            res0.kind       = KIND_BYTE;
            res0.status     = STATUS_OK;
            res0.value      = e_byte;
            res0.final_flag = !f_en;
        end
        else
        begin
            res0.kind       = KIND_FINISH;
            res0.status     = f_status;
            res0.value      = CH_NUL;
            res0.final_flag = 1'b1;
        end
        res1.kind       = KIND_FINISH;
        res1.status     = f_status;
        res1.value      = CH_NUL;
        res1.final_flag = 1'b1;
        push_n = {1'b0, res0_en} + {1'b0, res1_en};
    end

    // Next parse state
    always_comb
    begin
        phase_next = phase_reg;
        hex_next   = hex_reg;
        count_next = count_reg;
        win_next   = win_reg;
        if (accept)
        begin
            if (in_last)
            begin
                phase_next = PH_SEARCH;
                hex_next   = '0;
                count_next = '0;
                for (int i = 0; i < KEY_WIN_LEN; i++)
                begin
                    win_next[i] = CH_NUL;
                end
            end
            else
            begin
                phase_next = (c_fin || limit_hit) ? PH_DONE : c_phase;
                hex_next   = c_hex;
                count_next = e_en ? count_inc : count_reg;
                if (c_shift)
                begin
                    for (int i = 0; i < KEY_WIN_LEN - 1; i++)
                    begin
                        win_next[i] = win_reg[i + 1];
                    end
                    win_next[KEY_WIN_LEN - 1] = in_byte;
                end
            end
        end
    end

    // Hold parse state and the byte limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEARCH;
            hex_reg   <= '0;
            count_reg <= '0;
            max_reg   <= MAX_BYTES_RESET;
            for (int i = 0; i < KEY_WIN_LEN; i++)
            begin
                win_reg[i] <= CH_NUL;
            end
        end
        else
        begin
            phase_reg <= phase_next;
            hex_reg   <= hex_next;
            count_reg <= count_next;
            win_reg   <= win_next;
            if (cfg_wr_en)
            begin
                max_reg <= cfg_wr_data;
            end
        end
    end

    // Queue fill level
    assign fill_next = fill_reg + (accept ? RQ_CNT_W'(push_n) : RQ_CNT_W'(0))
                     - (pop ? RQ_CNT_W'(1) : RQ_CNT_W'(0));

    // Advance the queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + RQ_PTR_W'(1);
            end
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + RQ_PTR_W'(push_n);
            end
        end
    end

    // Write the results of this beat into the queue
    always_ff @(posedge clk)
    begin
        if (accept && res0_en)
        begin
            rq_mem[wr_ptr_reg] <= res0;
        end
        if (accept && res1_en)
        begin
            rq_mem[wr_ptr_reg + RQ_PTR_W'(1)] <= res1;
        end
    end

    // Drive the output beat from the queue head
    assign m_axis_tvalid = (fill_reg != '0);
    assign m_axis_tdata  = rq_mem[rd_ptr_reg].value;
    assign m_axis_tuser  = {rq_mem[rd_ptr_reg].status, rq_mem[rd_ptr_reg].kind};
    assign m_axis_tlast  = rq_mem[rd_ptr_reg].final_flag;

endmodule

FILE: verif/jsfe_checker.sv
// Scoreboard for the JSON string field extractor: predicts the result beats of every
// accepted text byte and compares them with the output stream, beat by beat.
// Depends on jsfe_pkg for the phase type, character codes and the result type.
`timescale 1ns / 100ps

module jsfe_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic        s_tlast,    // last_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // [7:0] value_byte
    input  logic [1:0]  m_tuser,    // [0] result_kind, [1] finish_status
    input  logic        m_tlast,    // final_of_item
    output int          mismatch_count,
    output int          pending_count
);
    import jsfe_pkg::*;

    // Key with both quotes, first character in the top byte
    localparam logic [71:0] KEY_WORD = "\"content\"";

    // Shadow copy of the parser state and the byte limit
    logic [63:0] recent_bytes;
    phase_t      phase;
    logic [2:0]  hex_left;
    logic [15:0] value_count;
    logic [15:0] byte_limit;

    // Results of the current beat, then the store of results still to arrive
    result_t     beat_res [2];
    int          beat_res_n;
    bit          text_done;
    result_t     value_q [$];
    result_t     want;
    bit          key_hit;
    int          errors;

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    task automatic clear_text();
        recent_bytes = '0;
        phase        = PH_SEARCH;
        hex_left     = '0;
        value_count  = '0;
    endtask

    task automatic post_result(input logic kind, input logic [7:0] val, input logic st);
        beat_res[beat_res_n].kind       = kind;
        beat_res[beat_res_n].status     = st;
        beat_res[beat_res_n].value      = val;
        beat_res[beat_res_n].final_flag = 1'b0;
        beat_res_n++;
    endtask

    // Close the text once per beat; later closes in the same beat are dropped
    task automatic close_text(input logic st);
        if (!text_done)
        begin
            post_result(KIND_FINISH, CH_NUL, st);
            text_done = 1'b1;
            phase     = PH_DONE;
        end
    endtask

    // Emit one value byte and stop at the byte limit
    task automatic emit_value(input logic [7:0] b);
        if (!text_done)
        begin
            post_result(KIND_BYTE, b, STATUS_OK);
            value_count = value_count + 16'd1;
            if (value_count >= byte_limit)
                close_text(STATUS_OK);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_text();
            byte_limit = MAX_BYTES_RESET;
            value_q.delete();
            errors = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                byte_limit = cfg_wr_data;

            // Predict the results of an accepted text beat
            if (s_tvalid && s_tready)
            begin
                beat_res_n = 0;
                text_done  = 1'b0;
                case (phase)
                    PH_SEARCH:
                    begin
                        if (s_tdata == CH_NUL)
                            close_text(STATUS_FAIL);
                        else
                        begin
                            key_hit = (s_tdata == CH_QUOTE) && (recent_bytes == KEY_WORD[71:8]);
                            recent_bytes = {recent_bytes[55:0], s_tdata};
                            if (key_hit)
                                phase = PH_WS1;
                        end
                    end
                    PH_WS1:
                    begin
                        if (s_tdata == CH_COLON)
                            phase = PH_WS2;
                        else if (!is_blank(s_tdata))
                            close_text(STATUS_FAIL);
                    end
                    PH_WS2:
                    begin
                        if (s_tdata == CH_QUOTE)
                        begin
                            phase = PH_VALUE;
                            if (byte_limit == 16'd0)
                                close_text(STATUS_OK);
                        end
                        else if (!is_blank(s_tdata))
                            close_text(STATUS_FAIL);
                    end
                    PH_VALUE:
                    begin
                        if (s_tdata == CH_NUL || s_tdata == CH_QUOTE)
                            close_text(STATUS_OK);
                        else if (s_tdata == CH_BACKSLASH)
                            phase = PH_ESC;
                        else
                            emit_value(s_tdata);
                    end
                    PH_ESC:
                    begin
                        phase = PH_VALUE;
                        if (s_tdata == CH_NUL)
                        begin
                            emit_value(CH_BACKSLASH);
                            close_text(STATUS_OK);
                        end
                        else if (s_tdata == CH_LOWER_U)
                        begin
                            phase    = PH_HEX;
                            hex_left = HEX_DIGITS;
                        end
                        else if (s_tdata == CH_LOWER_N)
                            emit_value(CH_LF);
                        else if (s_tdata == CH_LOWER_R)
                            emit_value(CH_CR);
                        else if (s_tdata == CH_LOWER_T)
                            emit_value(CH_TAB);
                        else
                            emit_value(s_tdata);
                    end
                    PH_HEX:
                    begin
                        if (s_tdata == CH_NUL)
                            close_text(STATUS_FAIL);
                        else
                        begin
                            hex_left = hex_left - 3'd1;
                            if (hex_left == 3'd0)
                            begin
                                phase = PH_VALUE;
                                emit_value(CH_QMARK);
                            end
                        end
                    end
                    default: ;
                endcase

                // End of text: close whatever is open, then start over
                if (s_tlast)
                begin
                    if (phase == PH_VALUE)
                        close_text(STATUS_OK);
                    else if (phase == PH_ESC)
                    begin
                        emit_value(CH_BACKSLASH);
                        close_text(STATUS_OK);
                    end
                    else if (phase != PH_DONE)
                        close_text(STATUS_FAIL);
                    clear_text();
                end

                if (beat_res_n > 0)
                    beat_res[beat_res_n - 1].final_flag = 1'b1;
                for (int i = 0; i < beat_res_n; i++)
                    value_q.push_back(beat_res[i]);
            end

            // Compare an accepted result beat with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (value_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat: kind=%0d st=%0d byte=%02h last=%0d",
                                 m_tuser[0], m_tuser[1], m_tdata, m_tlast);
                end
                else
                begin
                    want = value_q.pop_front();
                    if (m_tuser[0] !== want.kind || m_tuser[1] !== want.status ||
                        m_tdata !== want.value || m_tlast !== want.final_flag)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $write("mismatch: want kind=%0d st=%0d byte=%02h last=%0d,",
                                   want.kind, want.status, want.value, want.final_flag);
                            $display(" got kind=%0d st=%0d byte=%02h last=%0d",
                                     m_tuser[0], m_tuser[1], m_tdata, m_tlast);
                        end
                    end
                end
            end

            mismatch_count <= errors;
            pending_count  <= value_q.size();
        end
    end

endmodule

FILE: verif/testbench.sv
// Top of the extractor testbench: clock, reset, text stimulus, output back-pressure
// and the verdict. Depends on jsfe_pkg, json_string_field_extractor and jsfe_checker.
`timescale 1ns / 100ps

module testbench;
    import jsfe_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BEATS  = 215;
    localparam int PHASE_COUNT  = 6;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [15:0] cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int          send_idle_pct = 30;
    int          recv_idle_pct = 45;
    int          mismatches;
    int          outstanding;
    int          cycles = 0;
    int          beats_sent = 0;
    logic [7:0]  text_q [$];

    json_string_field_extractor u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    jsfe_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_axis_tvalid),
        .s_tready       (s_axis_tready),
        .s_tdata        (s_axis_tdata),
        .s_tlast        (s_axis_tlast),
        .m_tvalid       (m_axis_tvalid),
        .m_tready       (m_axis_tready),
        .m_tdata        (m_axis_tdata),
        .m_tuser        (m_axis_tuser),
        .m_tlast        (m_axis_tlast),
        .mismatch_count (mismatches),
        .pending_count  (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stall the output side at random
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic add_blank();
        case ($urandom_range(3))
            0: text_q.push_back(CH_SPACE);
            1: text_q.push_back(CH_TAB);
            2: text_q.push_back(CH_LF);
            default: text_q.push_back(CH_CR);
        endcase
    endtask

    // Append the key, the colon and the opening quote, with optional blanks
    task automatic add_hdr(input bit blanks);
        add_str("\"content\"");
        if (blanks)
            repeat ($urandom_range(0, 2)) add_blank();
        text_q.push_back(CH_COLON);
        if (blanks)
            repeat ($urandom_range(0, 2)) add_blank();
        text_q.push_back(CH_QUOTE);
    endtask

    // Send the built text beat by beat, tlast on the final byte
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= text_q[i];
            s_axis_tlast  <= (i == text_q.size() - 1);
            do
                @(posedge clk);
            while (!s_axis_tready);
            beats_sent++;
        end
        text_q.delete();
    endtask

    // Hold off the input until every predicted result has come out
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        int         target;
        int         cut;
        logic [7:0] c;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts at the reset limit: escapes, byte extremes, a split key
        add_str("xy\"conte\"content\" \t:\n\r\"");
        add_str("A\\n\\r\\t\\u12aB\\\"\\\\\\/");
        text_q.push_back(8'hFF);
        text_q.push_back(8'h80);
        text_q.push_back(8'h01);
        add_str("\"zz");
        send_text();
        // zero byte while searching, then an ignored tail
        text_q.push_back(CH_NUL);
        add_str("q");
        send_text();
        // text ends while searching
        add_str("x");
        send_text();
        // junk before the colon, and text ending before the opening quote
        add_str("\"content\"\tx");
        send_text();
        add_str("\"content\":");
        send_text();
        // zero byte inside a unicode escape
        add_hdr(0);
        add_str("ab\\u12");
        text_q.push_back(CH_NUL);
        add_str("z");
        send_text();
        // text ends on a lone backslash
        add_hdr(0);
        add_str("a\\");
        send_text();
        // zero byte right after a backslash
        add_hdr(0);
        add_str("a\\");
        text_q.push_back(CH_NUL);
        add_str("k");
        send_text();
        // text ends inside the value, and inside a unicode escape
        add_hdr(0);
        add_str("abc");
        send_text();
        add_hdr(0);
        add_str("\\u1");
        send_text();
        // zero limit, then a limit reached by an escape
        wait_idle();
        write_limit(16'd0);
        add_hdr(0);
        add_str("x\"");
        send_text();
        wait_idle();
        write_limit(16'd2);
        add_hdr(0);
        add_str("a\\nbc\"");
        send_text();

        // Random phases, each with its own limit; the idle pattern changes every two phases
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            wait_idle();
            if (ph < 2)
            begin
                send_idle_pct = 30;
                recv_idle_pct = 45;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0: write_limit(16'd1);
                1: write_limit(16'hFFFF);
                2: write_limit(16'($urandom_range(2, 12)));
                3: write_limit(16'd0);
                4: write_limit(16'($urandom_range(2, 40)));
                default: write_limit(MAX_BYTES_RESET);
            endcase

            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target)
            begin
                if ($urandom_range(99) < 75)
                begin
                    // Mostly well-formed texts with random content
                    repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(1, 255)));
                    if ($urandom_range(3) == 0)
                        add_str("\"cont");
                    if ($urandom_range(9) == 0)
                    begin
                        add_str("\"content\"");
                        if ($urandom_range(1) == 0)
                            add_blank();
                        text_q.push_back(8'($urandom_range(1, 255)));
                    end
                    else
                        add_hdr(1);
                    repeat ($urandom_range(0, 10))
                    begin
                        if ($urandom_range(3) != 0)
                        begin
                            // plain byte, nudged off quote and backslash
                            c = 8'($urandom_range(1, 255));
                            if (c == CH_QUOTE || c == CH_BACKSLASH)
                                c = c ^ 8'h01;
                            text_q.push_back(c);
                        end
                        else
                        begin
                            text_q.push_back(CH_BACKSLASH);
                            case ($urandom_range(6))
                                0: text_q.push_back(CH_LOWER_N);
                                1: text_q.push_back(CH_LOWER_R);
                                2: text_q.push_back(CH_LOWER_T);
                                3:
                                begin
                                    text_q.push_back(CH_LOWER_U);
                                    repeat (4) text_q.push_back(8'($urandom_range(1, 255)));
                                end
                                4: text_q.push_back(CH_QUOTE);
                                5: text_q.push_back(CH_BACKSLASH);
                                default: text_q.push_back(8'($urandom_range(1, 255)));
                            endcase
                        end
                    end
                    // Pick how the text ends
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4, 5:
                        begin
                            text_q.push_back(CH_QUOTE);
                            repeat ($urandom_range(0, 3))
                                text_q.push_back(8'($urandom_range(0, 255)));
                        end
                        6: ;
                        7:
                        begin
                            text_q.push_back(CH_NUL);
                            text_q.push_back(8'($urandom_range(0, 255)));
                        end
                        default:
                        begin
                            cut = $urandom_range(1, text_q.size());
                            while (text_q.size() > cut)
                                void'(text_q.pop_back());
                        end
                    endcase
                end
                else
                begin
                    // Noise text
                    repeat ($urandom_range(1, 16)) text_q.push_back(8'($urandom_range(0, 255)));
                end
                send_text();
                if ($urandom_range(19) == 0)
                    wait_idle();
            end
        end

        // Drain and give the verdict
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
